@@ rtl/smf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types, constants and the slot clock table of the snapshot morph unit.
// ----------------------------------------------------------------------------
package smf_pkg;

   localparam int SLOT_COUNT = 12;
   localparam int MAX_EMIT   = 32;

   // divider widths
   localparam int DIV_DW = 50;
   localparam int DIV_VW = 34;

   typedef logic [DIV_DW-1:0] div_word_type;
   typedef logic [DIV_VW-1:0] div_den_type;

   // request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_ATTR  = 2'd1;
   localparam logic [1:0] MODE_FADER = 2'd2;
   localparam logic [1:0] MODE_XY    = 2'd3;

   // register indexes
   localparam logic CSR_MIN_DIST   = 1'b0;
   localparam logic CSR_MIN_WEIGHT = 1'b1;

   localparam logic [27:0] MIN_DIST_RESET   = 28'd268;
   localparam logic [31:0] MIN_WEIGHT_RESET = 32'd1;
   localparam logic [9:0]  MASS_RESET       = 10'd256;
   localparam logic [9:0]  MASS_MIN         = 10'd26;
   localparam logic [9:0]  MASS_MAX         = 10'd768;
   localparam logic [15:0] VALUE_HALF       = 16'd32768;

   // slot positions on the unit clock circle, q2.14
   function automatic logic signed [15:0] clk_x(input logic [3:0] i);
      logic signed [15:0] r;
      unique case (i)
         4'd0:    r = 16'sd0;
         4'd1:    r = 16'sd8192;
         4'd2:    r = 16'sd14189;
         4'd3:    r = 16'sd16384;
         4'd4:    r = 16'sd14189;
         4'd5:    r = 16'sd8192;
         4'd6:    r = 16'sd0;
         4'd7:    r = -16'sd8192;
         4'd8:    r = -16'sd14189;
         4'd9:    r = -16'sd16384;
         4'd10:   r = -16'sd14189;
         4'd11:   r = -16'sd8192;
         default: r = 16'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] clk_y(input logic [3:0] i);
      logic signed [15:0] r;
      unique case (i)
         4'd0:    r = -16'sd16384;
         4'd1:    r = -16'sd14189;
         4'd2:    r = -16'sd8192;
         4'd3:    r = 16'sd0;
         4'd4:    r = 16'sd8192;
         4'd5:    r = 16'sd14189;
         4'd6:    r = 16'sd16384;
         4'd7:    r = 16'sd14189;
         4'd8:    r = 16'sd8192;
         4'd9:    r = 16'sd0;
         4'd10:   r = -16'sd8192;
         4'd11:   r = -16'sd14189;
         default: r = 16'sd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/smf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  smf_pkg::div_word_type dividend,
   input  smf_pkg::div_den_type  divisor,
   output logic                 done,
   output smf_pkg::div_word_type quotient
);
   import smf_pkg::*;

   localparam int CNTW = $clog2(DIV_DW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   div_word_type      quo_ff, quo_in;
   div_den_type       rem_ff, rem_in;
   div_den_type       den_ff, den_in;
   logic [DIV_VW:0]   rem_sh;
   logic              ge;

   assign rem_sh = {rem_ff, quo_ff[DIV_DW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(DIV_DW);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_VW'(rem_sh - {1'b0, den_ff}) : DIV_VW'(rem_sh);
         quo_in = {quo_ff[DIV_DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/snapshot_morph_fader_xy_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snapshot_morph_fader_xy_unit
// Twelve snapshot slots morphed by a fader or by inverse distance on an xy pad.
// ----------------------------------------------------------------------------
// Usage: items enter on the req_ stream, mode in req_tuser. Write modes load a
// snapshot value or slot attributes in the accept cycle and emit nothing. A
// fader or xy item emits one rsp_ item per parameter, index ascending, with
// rsp_tlast on the last one (at most 32 items).
// Register writes on the csr_ channel are always taken.
// Sequence: a fader item scans the twelve slots, then blends each parameter from
// two snapshot reads. xy walks each occupied slot through a divide, then each
// parameter through a multiply-accumulate over the slots and a divide, both on
// the shared divider. Snapping to a slot or holding reads one value per
// parameter; an all-half fader emits the constant half value.
// One item at a time: req_tready is low while a morph runs.
// A stalled receiver stops the sequencer at the pending result.
// Reset: a clearing pass over every snapshot address zeroes the snapshot and
// held memories; req_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module snapshot_morph_fader_xy_unit #(
   parameter int NUM_PARAMS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot_index, param_index, param_value_in, occupied_in, mass_in,
   // fader_position, cursor_x, cursor_y
   input  logic [87:0] req_tdata,
   // mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_index, out_value
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import smf_pkg::*;

   localparam int EMIT   = (NUM_PARAMS < MAX_EMIT) ? NUM_PARAMS : MAX_EMIT;
   localparam int PCW    = $clog2(NUM_PARAMS + 1);
   localparam int HAW    = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam int SDEPTH = SLOT_COUNT * NUM_PARAMS;
   localparam int SAW    = $clog2(SDEPTH);

   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_F_FIND  = 5'd2;
   localparam logic [4:0] S_X_TEST  = 5'd3;
   localparam logic [4:0] S_X_DX    = 5'd4;
   localparam logic [4:0] S_X_DY    = 5'd5;
   localparam logic [4:0] S_X_CHK   = 5'd6;
   localparam logic [4:0] S_X_DIV   = 5'd7;
   localparam logic [4:0] S_X_TOT   = 5'd8;
   localparam logic [4:0] S_X_K     = 5'd9;
   localparam logic [4:0] S_X_SHIFT = 5'd10;
   localparam logic [4:0] S_P_START = 5'd11;
   localparam logic [4:0] S_P_RD    = 5'd12;
   localparam logic [4:0] S_F_A     = 5'd13;
   localparam logic [4:0] S_F_B     = 5'd14;
   localparam logic [4:0] S_I_MAC   = 5'd15;
   localparam logic [4:0] S_I_DIV   = 5'd16;
   localparam logic [4:0] S_P_PUT   = 5'd17;
   localparam logic [4:0] S_P_WAIT  = 5'd18;

   localparam logic [2:0] K_HALF = 3'd0;
   localparam logic [2:0] K_FADE = 3'd1;
   localparam logic [2:0] K_COPY = 3'd2;
   localparam logic [2:0] K_HOLD = 3'd3;
   localparam logic [2:0] K_IDW  = 3'd4;

   localparam logic [3:0] SLOT_LAST = 4'(SLOT_COUNT - 1);

   function automatic logic [SAW-1:0] saddr(input logic [3:0] s, input logic [PCW-1:0] p);
      return SAW'(SAW'(s) * SAW'(NUM_PARAMS) + SAW'(p));
   endfunction

   // input fields
   logic [1:0]         f_mode;
   logic [3:0]         f_slot;
   logic [4:0]         f_param;
   logic [15:0]        f_value;
   logic               f_occ;
   logic [9:0]         f_mass;
   logic [15:0]        f_pos;
   logic signed [15:0] f_cx, f_cy;

   assign f_mode  = req_tuser;
   assign f_slot  = req_tdata[3:0];
   assign f_param = req_tdata[8:4];
   assign f_value = req_tdata[24:9];
   assign f_occ   = req_tdata[25];
   assign f_mass  = req_tdata[35:26];
   assign f_pos   = req_tdata[51:36];
   assign f_cx    = req_tdata[67:52];
   assign f_cy    = req_tdata[83:68];

   // state
   logic [4:0]         state_ff, state_in;
   logic [SAW-1:0]     clr_ff, clr_in;
   logic [PCW-1:0]     p_ff, p_in;
   logic [3:0]         i_ff, i_in;
   logic [3:0]         c_ff, c_in;
   logic [2:0]         kind_ff, kind_in;
   logic [3:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [3:0]         slo_ff, slo_in, shi_ff, shi_in;
   logic [15:0]        alpha_ff, alpha_in;
   logic signed [15:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [33:0]        dsq_ff, dsq_in;
   logic [49:0]        total_ff, total_in;
   logic [49:0]        tsh_ff, tsh_in;
   logic [4:0]         k_ff, k_in;
   logic [31:0]        tots_ff, tots_in;
   logic [49:0]        acc_ff, acc_in;
   logic [15:0]        val_ff, val_in;
   logic [11:0]        occ_ff, occ_in;
   logic [9:0]         mass_ff [SLOT_COUNT];
   logic [9:0]         mass_in [SLOT_COUNT];
   logic [45:0]        w_ff [SLOT_COUNT];
   logic [45:0]        w_in [SLOT_COUNT];
   logic [27:0]        mds_ff, mds_in;
   logic [31:0]        mtw_ff, mtw_in;
   logic               rv_ff, rv_in;
   logic [4:0]         ridx_ff, ridx_in;
   logic [15:0]        rval_ff, rval_in;
   logic               rlast_ff, rlast_in;

   // memories
   logic [15:0]    snap_mem [SDEPTH];
   logic [15:0]    held_mem [NUM_PARAMS];
   logic [15:0]    snap_rd_ff, held_rd_ff;
   logic           snap_we, held_we, put_we;
   logic [SAW-1:0] snap_wa, snap_ra;
   logic [15:0]    snap_wd, held_wd;
   logic [HAW-1:0] held_wa, held_ra;
   logic           clearing, accept, mem_write;

   // shared multiplier and divider
   logic [15:0]    mul_x;
   logic [32:0]    mul_y;
   logic [48:0]    prod;
   logic           div_start, div_done;
   div_word_type   div_dividend, div_q;
   div_den_type    div_divisor;

   // helpers
   logic [3:0]         n_occ, n_m1;
   logic [19:0]        fs;
   logic [3:0]         f_lo, f_hi;
   logic signed [17:0] dx, dy;
   logic [15:0]        adx, ady;
   logic [45:0]        ws;
   logic [49:0]        fsum, isum;
   logic [9:0]         mass_sat;

   assign clearing  = (state_ff == S_CLEAR);
   assign req_tready = (state_ff == S_IDLE);
   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign mem_write = accept && (f_mode == MODE_WRITE) && (32'(f_slot) < SLOT_COUNT)
                      && (32'(f_param) < NUM_PARAMS);

   assign snap_we = clearing || mem_write;
   assign snap_wa = clearing ? clr_ff : saddr(f_slot, PCW'(f_param));
   assign snap_wd = clearing ? 16'd0 : f_value;
   assign held_we = (clearing && (32'(clr_ff) < NUM_PARAMS)) || put_we;
   assign held_wa = clearing ? clr_ff[HAW-1:0] : p_ff[HAW-1:0];
   assign held_wd = clearing ? 16'd0 : val_ff;

   always_ff @(posedge clock) begin
      if (snap_we) begin
         snap_mem[snap_wa] <= snap_wd;
      end
      snap_rd_ff <= snap_mem[snap_ra];
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_mem[held_wa] <= held_wd;
      end
      held_rd_ff <= held_mem[held_ra];
   end

   assign n_occ = 4'($countones(occ_ff));
   assign n_m1  = n_occ - 4'd1;
   assign fs    = 20'(f_pos) * 20'(n_m1);
   assign f_lo  = (fs[19:16] > n_m1) ? n_m1 : fs[19:16];
   assign f_hi  = (f_lo + 4'd1 > n_m1) ? n_m1 : f_lo + 4'd1;
   assign dx    = 18'(cx_ff) - 18'(clk_x(i_ff));
   assign dy    = 18'(cy_ff) - 18'(clk_y(i_ff));
   assign adx   = dx[17] ? 16'(-dx) : 16'(dx);
   assign ady   = dy[17] ? 16'(-dy) : 16'(dy);
   assign ws    = w_ff[i_ff] >> k_ff;
   assign prod  = 49'(mul_x) * 49'(mul_y);
   assign fsum  = acc_ff + 50'(prod) + 50'd32768;
   assign isum  = acc_ff + 50'(prod) + 50'(tots_ff >> 1);
   assign mass_sat = (f_mass < MASS_MIN) ? MASS_MIN : ((f_mass > MASS_MAX) ? MASS_MAX : f_mass);

   smf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      p_in     = p_ff;
      i_in     = i_ff;
      c_in     = c_ff;
      kind_in  = kind_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      slo_in   = slo_ff;
      shi_in   = shi_ff;
      alpha_in = alpha_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      dsq_in   = dsq_ff;
      total_in = total_ff;
      tsh_in   = tsh_ff;
      k_in     = k_ff;
      tots_in  = tots_ff;
      acc_in   = acc_ff;
      val_in   = val_ff;
      occ_in   = occ_ff;
      mass_in  = mass_ff;
      w_in     = w_ff;
      mds_in   = mds_ff;
      mtw_in   = mtw_ff;
      rv_in    = rv_ff && !rsp_tready;
      ridx_in  = ridx_ff;
      rval_in  = rval_ff;
      rlast_in = rlast_ff;
      snap_ra  = '0;
      held_ra  = p_ff[HAW-1:0];
      put_we   = 1'b0;
      mul_x    = snap_rd_ff;
      mul_y    = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      if (csr_valid) begin
         if (csr_index == CSR_MIN_DIST) begin
            mds_in = csr_data[27:0];
         end else begin
            mtw_in = csr_data;
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SAW'(SDEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               p_in = '0;
               i_in = '0;
               c_in = '0;
               unique case (f_mode)
                  MODE_WRITE: begin
                  end
                  MODE_ATTR: begin
                     if (32'(f_slot) < SLOT_COUNT) begin
                        occ_in[f_slot]  = f_occ;
                        mass_in[f_slot] = mass_sat;
                     end
                  end
                  MODE_FADER: begin
                     if (n_occ == 4'd0) begin
                        kind_in  = K_HALF;
                        state_in = S_P_START;
                     end else begin
                        kind_in  = K_FADE;
                        lo_in    = f_lo;
                        hi_in    = f_hi;
                        alpha_in = fs[15:0];
                        state_in = S_F_FIND;
                     end
                  end
                  MODE_XY: begin
                     cx_in    = f_cx;
                     cy_in    = f_cy;
                     total_in = '0;
                     state_in = S_X_TEST;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_F_FIND: begin
            if (occ_ff[i_ff]) begin
               if (c_ff == lo_ff) begin
                  slo_in = i_ff;
               end
               if (c_ff == hi_ff) begin
                  shi_in = i_ff;
               end
               c_in = c_ff + 4'd1;
            end
            i_in = i_ff + 4'd1;
            if (i_ff == SLOT_LAST) begin
               state_in = S_P_START;
            end
         end
         S_X_TEST: begin
            if (occ_ff[i_ff]) begin
               state_in = S_X_DX;
            end else begin
               w_in[i_ff] = '0;
               i_in = i_ff + 4'd1;
               if (i_ff == SLOT_LAST) begin
                  state_in = S_X_TOT;
               end
            end
         end
         S_X_DX: begin
            mul_x    = adx;
            mul_y    = 33'(adx);
            dsq_in   = 34'(prod);
            state_in = S_X_DY;
         end
         S_X_DY: begin
            mul_x    = ady;
            mul_y    = 33'(ady);
            dsq_in   = dsq_ff + 34'(prod);
            state_in = S_X_CHK;
         end
         S_X_CHK: begin
            if (dsq_ff < 34'(mds_ff)) begin
               slo_in   = i_ff;
               kind_in  = K_COPY;
               state_in = S_P_START;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_DW'(mass_ff[i_ff]) << 36;
               div_divisor  = (dsq_ff == 34'd0) ? DIV_VW'(1) : DIV_VW'(dsq_ff);
               state_in     = S_X_DIV;
            end
         end
         S_X_DIV: begin
            if (div_done) begin
               w_in[i_ff] = div_q[45:0];
               total_in   = total_ff + 50'(div_q[45:0]);
               i_in       = i_ff + 4'd1;
               state_in   = (i_ff == SLOT_LAST) ? S_X_TOT : S_X_TEST;
            end
         end
         S_X_TOT: begin
            if (total_ff < 50'(mtw_ff)) begin
               kind_in  = K_HOLD;
               state_in = S_P_START;
            end else begin
               tsh_in   = total_ff;
               k_in     = '0;
               state_in = S_X_K;
            end
         end
         S_X_K: begin
            if (tsh_ff[49:32] != 18'd0) begin
               tsh_in = tsh_ff >> 1;
               k_in   = k_ff + 5'd1;
            end else begin
               i_in     = '0;
               tots_in  = '0;
               state_in = S_X_SHIFT;
            end
         end
         S_X_SHIFT: begin
            w_in[i_ff] = ws;
            tots_in    = tots_ff + ws[31:0];
            i_in       = i_ff + 4'd1;
            if (i_ff == SLOT_LAST) begin
               kind_in  = K_IDW;
               state_in = S_P_START;
            end
         end
         S_P_START: begin
            unique case (kind_ff)
               K_HALF: begin
                  val_in   = VALUE_HALF;
                  state_in = S_P_PUT;
               end
               K_COPY: begin
                  snap_ra  = saddr(slo_ff, p_ff);
                  state_in = S_P_RD;
               end
               K_HOLD: begin
                  state_in = S_P_RD;
               end
               K_FADE: begin
                  snap_ra  = saddr(slo_ff, p_ff);
                  state_in = S_F_A;
               end
               K_IDW: begin
                  if (tots_ff == 32'd0) begin
                     val_in   = 16'd0;
                     state_in = S_P_PUT;
                  end else begin
                     snap_ra  = saddr(4'd0, p_ff);
                     i_in     = 4'd1;
                     acc_in   = '0;
                     state_in = S_I_MAC;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_P_RD: begin
            val_in   = (kind_ff == K_HOLD) ? held_rd_ff : snap_rd_ff;
            state_in = S_P_PUT;
         end
         S_F_A: begin
            snap_ra  = saddr(shi_ff, p_ff);
            mul_y    = 33'(17'h10000 - 17'(alpha_ff));
            acc_in   = 50'(prod);
            state_in = S_F_B;
         end
         S_F_B: begin
            mul_y    = 33'(alpha_ff);
            val_in   = (fsum[49:16] > 34'd65535) ? 16'hFFFF : fsum[31:16];
            state_in = S_P_PUT;
         end
         S_I_MAC: begin
            mul_y = 33'(w_ff[i_ff - 4'd1][31:0]);
            if (32'(i_ff) < SLOT_COUNT) begin
               acc_in   = acc_ff + 50'(prod);
               snap_ra  = saddr(i_ff, p_ff);
               i_in     = i_ff + 4'd1;
            end else begin
               div_start    = 1'b1;
               div_dividend = isum;
               div_divisor  = DIV_VW'(tots_ff);
               state_in     = S_I_DIV;
            end
         end
         S_I_DIV: begin
            if (div_done) begin
               val_in   = (div_q > DIV_DW'(65535)) ? 16'hFFFF : div_q[15:0];
               state_in = S_P_PUT;
            end
         end
         S_P_PUT: begin
            put_we = (kind_ff != K_HOLD);
            if (32'(p_ff) < EMIT) begin
               rv_in    = 1'b1;
               ridx_in  = 5'(p_ff);
               rval_in  = val_ff;
               rlast_in = (p_ff == PCW'(EMIT - 1));
               state_in = S_P_WAIT;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = (p_ff == PCW'(NUM_PARAMS - 1)) ? S_IDLE : S_P_START;
            end
         end
         S_P_WAIT: begin
            if (rsp_tready) begin
               p_in     = p_ff + 1'b1;
               state_in = (p_ff == PCW'(NUM_PARAMS - 1)) ? S_IDLE : S_P_START;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         occ_ff   <= '0;
         mds_ff   <= MIN_DIST_RESET;
         mtw_ff   <= MIN_WEIGHT_RESET;
         rv_ff    <= 1'b0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            mass_ff[s] <= MASS_RESET;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         occ_ff   <= occ_in;
         mds_ff   <= mds_in;
         mtw_ff   <= mtw_in;
         rv_ff    <= rv_in;
         mass_ff  <= mass_in;
      end
      p_ff     <= p_in;
      i_ff     <= i_in;
      c_ff     <= c_in;
      kind_ff  <= kind_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      slo_ff   <= slo_in;
      shi_ff   <= shi_in;
      alpha_ff <= alpha_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      dsq_ff   <= dsq_in;
      total_ff <= total_in;
      tsh_ff   <= tsh_in;
      k_ff     <= k_in;
      tots_ff  <= tots_in;
      acc_ff   <= acc_in;
      val_ff   <= val_in;
      w_ff     <= w_in;
      ridx_ff  <= ridx_in;
      rval_ff  <= rval_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {3'b000, rval_ff, ridx_ff};
   assign rsp_tlast  = rlast_ff;

   a_rsp_in_wait : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == S_P_WAIT))
      else $error("result pending outside the wait state");

   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while a result is pending");

   a_div_owner : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_X_DIV || state_ff == S_I_DIV))
      else $error("divider finished with no owner");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the snapshot morph unit: a driver and a monitor run
// random and directed write, attribute, fader and xy items through the block,
// a local model of the slots predicts every emitted value, and the register
// settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   import smf_pkg::*;

   localparam int NPAR       = 32;
   localparam int WDOG_LIMIT = 40000;

   typedef struct {
      logic [1:0]         mode;
      logic [3:0]         slot;
      logic [4:0]         param;
      logic [15:0]        pval;
      logic               occ;
      logic [9:0]         mass;
      logic [15:0]        fpos;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
   } req_item_t;

   typedef struct {
      logic [4:0]  idx;
      logic [15:0] val;
      logic        last;
   } morph_val_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;

   req_item_t  pending_q[$];
   morph_val_t expected_q[$];
   req_item_t  cur_item;
   bit         req_taken;
   bit         no_idle;
   bit         long_hold;
   int         hold_cnt;
   int         errors;
   int         wdog;

   // local copy of the slot state
   logic [15:0] snap_mem[SLOT_COUNT][NPAR];
   logic        occ_flags[SLOT_COUNT];
   logic [9:0]  masses[SLOT_COUNT];
   logic [15:0] held_vals[NPAR];
   logic [27:0] cfg_min_dist;
   logic [31:0] cfg_min_weight;

   const int ring_x[SLOT_COUNT] = '{0, 8192, 14189, 16384, 14189, 8192, 0,
                                    -8192, -14189, -16384, -14189, -8192};
   const int ring_y[SLOT_COUNT] = '{-16384, -14189, -8192, 0, 8192, 14189, 16384,
                                    14189, 8192, 0, -8192, -14189};

   snapshot_morph_fader_xy_unit #(.NUM_PARAMS(NPAR)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void morph_predict(req_item_t it);
      logic [15:0] vals[NPAR];
      int          list[SLOT_COUNT];
      int          n, lo, hi;
      logic [31:0] s;
      logic [63:0] alpha, a, b, v, acc, total, tot_s, dsq, dv;
      logic [63:0] w[SLOT_COUNT];
      longint      dx, dy;
      bit          snapped, keep;
      int          k;
      morph_val_t  r;
      logic [9:0]  m;
      n = 0;
      snapped = 0;
      keep = 1;
      case (it.mode)
         MODE_WRITE: begin
            if (it.slot < SLOT_COUNT && it.param < NPAR) snap_mem[it.slot][it.param] = it.pval;
            return;
         end
         MODE_ATTR: begin
            if (it.slot < SLOT_COUNT) begin
               m = it.mass;
               if (m < MASS_MIN) m = MASS_MIN;
               if (m > MASS_MAX) m = MASS_MAX;
               occ_flags[it.slot] = it.occ;
               masses[it.slot] = m;
            end
            return;
         end
         MODE_FADER: begin
            for (int i = 0; i < SLOT_COUNT; i++)
               if (occ_flags[i]) begin
                  list[n] = i;
                  n++;
               end
            if (n == 0) begin
               foreach (vals[p]) vals[p] = VALUE_HALF;
            end else if (n == 1) begin
               foreach (vals[p]) vals[p] = snap_mem[list[0]][p];
            end else begin
               s = {16'd0, it.fpos} * (n - 1);
               lo = int'(s >> 16);
               if (lo > n - 1) lo = n - 1;
               hi = (lo + 1 > n - 1) ? n - 1 : lo + 1;
               alpha = {48'd0, s[15:0]};
               foreach (vals[p]) begin
                  a = snap_mem[list[lo]][p];
                  b = snap_mem[list[hi]][p];
                  v = (a * (64'd65536 - alpha) + b * alpha + 64'd32768) >> 16;
                  vals[p] = (v > 65535) ? 16'hFFFF : v[15:0];
               end
            end
         end
         default: begin
            total = 0;
            for (int i = 0; i < SLOT_COUNT && !snapped; i++) begin
               w[i] = 0;
               if (!occ_flags[i]) continue;
               dx = longint'(it.cx) - ring_x[i];
               dy = longint'(it.cy) - ring_y[i];
               dsq = dx * dx + dy * dy;
               if (dsq < cfg_min_dist) begin
                  foreach (vals[p]) vals[p] = snap_mem[i][p];
                  snapped = 1;
               end else begin
                  dv = (dsq > cfg_min_dist) ? dsq : cfg_min_dist;
                  if (dv == 0) dv = 1;
                  w[i] = ({54'd0, masses[i]} << 36) / dv;
                  total += w[i];
               end
            end
            if (!snapped) begin
               if (total < cfg_min_weight) begin
                  keep = 0;
               end else begin
                  k = 0;
                  while ((total >> k) > 64'hFFFF_FFFF) k++;
                  tot_s = 0;
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                     w[i] = w[i] >> k;
                     tot_s += w[i];
                  end
                  foreach (vals[p]) begin
                     if (tot_s == 0) begin
                        vals[p] = 0;
                     end else begin
                        acc = 0;
                        for (int i = 0; i < SLOT_COUNT; i++) acc += snap_mem[i][p] * w[i];
                        v = (acc + tot_s / 2) / tot_s;
                        vals[p] = (v > 65535) ? 16'hFFFF : v[15:0];
                     end
                  end
               end
            end
         end
      endcase
      if (keep) held_vals = vals;
      for (int p = 0; p < NPAR && p < MAX_EMIT; p++) begin
         r.idx = 5'(p);
         r.val = held_vals[p];
         r.last = (p == ((NPAR < MAX_EMIT) ? NPAR : MAX_EMIT) - 1);
         expected_q.push_back(r);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         morph_predict(cur_item);
         req_taken = 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 0;
         if (pending_q.size() > 0 && (no_idle || $urandom_range(99) >= 31)) begin
            cur_item = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= cur_item.mode;
            req_tdata <= {4'd0, cur_item.cy, cur_item.cx, cur_item.fpos, cur_item.mass,
                          cur_item.occ, cur_item.pval, cur_item.param, cur_item.slot};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (long_hold) begin
         long_hold = 0;
         hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 31);
      end
   end

   // monitor
   always @(posedge clock) begin
      morph_val_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected item idx=%0d val=%0d last=%0d", $time,
                     rsp_tdata[4:0], rsp_tdata[20:5], rsp_tlast);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_tdata[4:0] !== e.idx || rsp_tdata[20:5] !== e.val || rsp_tlast !== e.last) begin
               $display("%0t: mismatch expected idx=%0d val=%0d last=%0d, got idx=%0d val=%0d last=%0d",
                        $time, e.idx, e.val, e.last, rsp_tdata[4:0], rsp_tdata[20:5], rsp_tlast);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         wdog <= 0;
      else
         wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_item_t random_item();
      req_item_t it;
      int        sel;
      it.mode  = $urandom_range(3);
      it.slot  = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(11);
      it.param = $urandom_range(31);
      it.pval  = $urandom_range(65535);
      it.occ   = ($urandom_range(99) < 70);
      it.mass  = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(26, 768);
      it.fpos  = $urandom_range(65535);
      sel = $urandom_range(9);
      if (sel < 2) begin
         it.slot = $urandom_range(11);
         it.cx = ring_x[it.slot] + $urandom_range(8) - 4;
         it.cy = ring_y[it.slot] + $urandom_range(8) - 4;
      end else if (sel < 4) begin
         it.cx = $urandom_range(65535);
         it.cy = $urandom_range(65535);
      end else begin
         it.cx = int'($urandom_range(40000)) - 20000;
         it.cy = int'($urandom_range(40000)) - 20000;
      end
      return it;
   endfunction

   function automatic req_item_t make_item(logic [1:0] md, logic [3:0] sl, logic [4:0] pr,
                                           logic [15:0] pv, logic oc, logic [9:0] ms,
                                           logic [15:0] fp, int x, int y);
      req_item_t it;
      it.mode = md;
      it.slot = sl;
      it.param = pr;
      it.pval = pv;
      it.occ = oc;
      it.mass = ms;
      it.fpos = fp;
      it.cx = x;
      it.cy = y;
      return it;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_tvalid || expected_q.size() != 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] d);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = d;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_MIN_DIST) cfg_min_dist = d[27:0];
      else cfg_min_weight = d;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_run(int count);
      req_item_t it;
      for (int i = 0; i < count; i++) begin
         // in about one pass of four, load four values first so the slots carry content
         if ($urandom_range(3) == 0) begin
            for (int j = 0; j < 4; j++) begin
               it = random_item();
               it.mode = MODE_WRITE;
               pending_q.push_back(it);
               i++;
            end
         end
         pending_q.push_back(random_item());
      end
   endtask

   initial begin
      req_item_t it;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_data = '0;
      req_taken = 0;
      no_idle = 0;
      long_hold = 0;
      hold_cnt = 0;
      errors = 0;
      wdog = 0;
      cfg_min_dist = MIN_DIST_RESET;
      cfg_min_weight = MIN_WEIGHT_RESET;
      foreach (snap_mem[i, p]) snap_mem[i][p] = '0;
      foreach (held_vals[p]) held_vals[p] = '0;
      foreach (occ_flags[i]) begin
         occ_flags[i] = 1'b0;
         masses[i] = MASS_RESET;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty slots, held output, extremes
      pending_q.push_back(make_item(MODE_FADER, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0));
      pending_q.push_back(make_item(MODE_XY, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_q.push_back(make_item(MODE_WRITE, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0));
      pending_q.push_back(make_item(MODE_WRITE, 11, 31, 16'hFFFF, 0, 0, 0, 0, 0));
      pending_q.push_back(make_item(MODE_WRITE, 15, 3, 16'h1234, 0, 0, 0, 0, 0));
      pending_q.push_back(make_item(MODE_WRITE, 5, 7, 16'd0, 1, 10'h3FF, 0, 0, 0));
      pending_q.push_back(make_item(MODE_ATTR, 0, 0, 0, 1, 10'd0, 0, 0, 0));
      pending_q.push_back(make_item(MODE_FADER, 0, 0, 0, 0, 0, 16'h8000, 0, 0));
      pending_q.push_back(make_item(MODE_ATTR, 11, 0, 0, 1, 10'h3FF, 0, 0, 0));
      pending_q.push_back(make_item(MODE_ATTR, 13, 0, 0, 1, 10'd100, 0, 0, 0));
      pending_q.push_back(make_item(MODE_FADER, 0, 0, 0, 0, 0, 16'd0, 0, 0));
      pending_q.push_back(make_item(MODE_FADER, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0));
      pending_q.push_back(make_item(MODE_ATTR, 6, 0, 0, 1, 10'd768, 0, 0, 0));
      pending_q.push_back(make_item(MODE_FADER, 0, 0, 0, 0, 0, 16'h7FFF, 0, 0));
      pending_q.push_back(make_item(MODE_XY, 0, 0, 0, 0, 0, 0, 0, -16384));
      pending_q.push_back(make_item(MODE_XY, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_q.push_back(make_item(MODE_XY, 0, 0, 0, 0, 0, 0, -32768, -32768));
      pending_q.push_back(make_item(MODE_XY, 0, 0, 0, 0, 0, 0, 32767, 32767));
      pending_q.push_back(make_item(MODE_XY, 0, 0, 0, 0, 0, 0, -8192, -14189));
      wait_idle();

      // zero thresholds: exact hit divides by one, empty pad gives zeros
      write_reg(CSR_MIN_DIST, 32'd0);
      write_reg(CSR_MIN_WEIGHT, 32'd0);
      pending_q.push_back(make_item(MODE_XY, 0, 0, 0, 0, 0, 0, 0, -16384));
      pending_q.push_back(make_item(MODE_XY, 0, 0, 0, 0, 0, 0, 16384, 0));
      for (int i = 0; i < SLOT_COUNT; i++)
         pending_q.push_back(make_item(MODE_ATTR, i, 0, 0, 0, 10'd256, 0, 0, 0));
      pending_q.push_back(make_item(MODE_XY, 0, 0, 0, 0, 0, 0, 100, 100));
      wait_idle();

      // maximum thresholds, with a long receiver hold-off
      write_reg(CSR_MIN_DIST, 32'h0FFF_FFFF);
      write_reg(CSR_MIN_WEIGHT, 32'hFFFF_FFFF);
      long_hold = 1;
      random_run(60);
      wait_idle();

      // thresholds back to reset values, no idling for a while
      write_reg(CSR_MIN_DIST, MIN_DIST_RESET);
      write_reg(CSR_MIN_WEIGHT, MIN_WEIGHT_RESET);
      no_idle = 1;
      random_run(60);
      wait_idle();
      no_idle = 0;

      for (int ph = 0; ph < 3; ph++) begin
         write_reg(CSR_MIN_DIST, $urandom_range(4000000));
         write_reg(CSR_MIN_WEIGHT, ($urandom_range(1) == 0) ? $urandom_range(4096) : $urandom);
         random_run(85);
         wait_idle();
      end

      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/smf_pkg.sv
rtl/smf_div.sv
rtl/snapshot_morph_fader_xy_unit.sv
verif/testbench.sv
